### hdl/shortest_job_next_queue_unit_defines.svh
// Assertion macros for the shortest-job-next queue checker.
`ifndef SHORTEST_JOB_NEXT_QUEUE_UNIT_DEFINES_SVH
`define SHORTEST_JOB_NEXT_QUEUE_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define SJNQ_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define SJNQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hdl/sjnq_pkg.sv
// Shared types, codes and the weight function of the shortest-job-next queue.
`timescale 1ns / 1ps

package sjnq_pkg;

   localparam int ID_W     = 16;
   localparam int WEIGHT_W = 20;
   localparam int FIELD_W  = 16;
   localparam int OCC_W    = 5;
   localparam int STATUS_W = 2;

   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

   localparam logic CMD_INSERT = 1'b0;
   localparam logic CMD_POP    = 1'b1;

   typedef struct packed {
      logic [ID_W-1:0]     id;
      logic [WEIGHT_W-1:0] weight;
   } entry_type;

   typedef struct packed {
      logic wr_en;
      logic advance;
   } store_ctl_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CALC,
      ST_WALK,
      ST_PLACE,
      ST_POP_READ,
      ST_POP_DONE
   } state_type;

   // weight = 5*labels + 3*functions + instructions, by shifts and adds
   function automatic logic [WEIGHT_W-1:0] calc_weight(
      input logic [FIELD_W-1:0] labels,
      input logic [FIELD_W-1:0] funcs,
      input logic [FIELD_W-1:0] instrs
   );
      logic [WEIGHT_W-1:0] l;
      logic [WEIGHT_W-1:0] f;
      logic [WEIGHT_W-1:0] n;
      l = WEIGHT_W'(labels);
      f = WEIGHT_W'(funcs);
      n = WEIGHT_W'(instrs);
      return (l << 2) + l + (f << 1) + f + n;
   endfunction

endpackage

### hdl/sjnq_store.sv
// Ring-buffer entry store: logical slots relative to a moving head, registered read.
`timescale 1ns / 1ps

module sjnq_store
   import sjnq_pkg::*;
#(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  store_ctl_type                  ctl,
   input  logic [$clog2(QUEUE_DEPTH)-1:0] wr_idx,
   input  entry_type                      wr_data,
   input  logic [$clog2(QUEUE_DEPTH)-1:0] rd_idx,
   output entry_type                      rd_data
);

   localparam int IDX_W = $clog2(QUEUE_DEPTH);

   entry_type mem [QUEUE_DEPTH];

   logic [IDX_W-1:0] head_ff;
   logic [IDX_W-1:0] head_in;
   logic [IDX_W-1:0] wr_phys;
   logic [IDX_W-1:0] rd_phys;
   entry_type        rd_data_ff;

   // Map a logical slot to its physical address: head + idx, wrapped once.
   function automatic logic [IDX_W-1:0] to_phys(
      input logic [IDX_W-1:0] head,
      input logic [IDX_W-1:0] idx
   );
      logic [IDX_W:0] sum;
      sum = {1'b0, head} + {1'b0, idx};
      if (sum >= (IDX_W+1)'(QUEUE_DEPTH)) begin
         sum = sum - (IDX_W+1)'(QUEUE_DEPTH);
      end
      return sum[IDX_W-1:0];
   endfunction

   assign wr_phys = to_phys(head_ff, wr_idx);
   assign rd_phys = to_phys(head_ff, rd_idx);

   always_comb begin
      head_in = head_ff;
      if (ctl.advance) begin
         if (head_ff == IDX_W'(QUEUE_DEPTH - 1)) begin
            head_in = '0;
         end else begin
            head_in = head_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
      end else begin
         head_ff <= head_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[wr_phys] <= wr_data;
      end
      rd_data_ff <= mem[rd_phys];
   end

   assign rd_data = rd_data_ff;

endmodule

### hdl/shortest_job_next_queue_unit.sv
// Shortest-job-next admission queue: sequencer, weight unit and response register.
`timescale 1ns / 1ps

// A request is taken when start is high and busy is low. An insert (req_cmd 0)
// computes weight = 5*labels + 3*functions + instructions, assigns the next job
// id, and walks the queue from its tail with one shared compare, moving one entry
// per cycle through the single write port of the entry store until it finds the
// slot. An insert goes through the calc state, one walk step for each queued
// entry that weighs at least as much (at most QUEUE_DEPTH - 1), and a last walk
// or place step; a rejected insert on a full queue ends in calc. A pop does the
// registered read of the head entry, then a done step, and on an empty queue
// ends in the read state. Every request gives exactly one response, shown for
// a single cycle with rsp_valid in the cycle busy falls; the receiver cannot
// stall it, and a new request may be started in that same cycle.

module shortest_job_next_queue_unit
   import sjnq_pkg::*;
#(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic                req_cmd,
   input  logic [FIELD_W-1:0]  req_label_count,
   input  logic [FIELD_W-1:0]  req_function_count,
   input  logic [FIELD_W-1:0]  req_instruction_count,
   output logic                rsp_valid,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [ID_W-1:0]     rsp_job_id,
   output logic [WEIGHT_W-1:0] rsp_job_weight,
   output logic [OCC_W-1:0]    rsp_occupancy
);

   localparam int IDX_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   state_type           state_ff, state_in;
   logic [FIELD_W-1:0]  labels_ff, labels_in;
   logic [FIELD_W-1:0]  funcs_ff, funcs_in;
   logic [FIELD_W-1:0]  instrs_ff, instrs_in;
   logic [WEIGHT_W-1:0] weight_ff, weight_in;
   logic [ID_W-1:0]     id_ff, id_in;
   logic [ID_W-1:0]     last_id_ff, last_id_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [IDX_W-1:0]    slot_ff, slot_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [ID_W-1:0]     rsp_id_ff, rsp_id_in;
   logic [WEIGHT_W-1:0] rsp_weight_ff, rsp_weight_in;
   logic [OCC_W-1:0]    rsp_occ_ff, rsp_occ_in;

   store_ctl_type       store_ctl;
   logic [IDX_W-1:0]    wr_idx;
   entry_type           wr_data;
   logic [IDX_W-1:0]    rd_idx;
   entry_type           rd_data;
   logic [WEIGHT_W-1:0] calc_sum;
   logic [ID_W-1:0]     next_id;
   entry_type           new_entry;

   assign calc_sum  = calc_weight(labels_ff, funcs_ff, instrs_ff);
   assign next_id   = last_id_ff + 1'b1;
   assign new_entry = '{id: id_ff, weight: weight_ff};
   assign busy      = (state_ff != ST_IDLE);

   sjnq_store #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_store (
      .clock   (clock),
      .reset   (reset),
      .ctl     (store_ctl),
      .wr_idx  (wr_idx),
      .wr_data (wr_data),
      .rd_idx  (rd_idx),
      .rd_data (rd_data)
   );

   always_comb begin
      state_in      = state_ff;
      labels_in     = labels_ff;
      funcs_in      = funcs_ff;
      instrs_in     = instrs_ff;
      weight_in     = weight_ff;
      id_in         = id_ff;
      last_id_in    = last_id_ff;
      count_in      = count_ff;
      slot_in       = slot_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_id_in     = rsp_id_ff;
      rsp_weight_in = rsp_weight_ff;
      rsp_occ_in    = rsp_occ_ff;
      store_ctl     = '{wr_en: 1'b0, advance: 1'b0};
      wr_idx        = slot_ff;
      wr_data       = new_entry;
      rd_idx        = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               labels_in = req_label_count;
               funcs_in  = req_function_count;
               instrs_in = req_instruction_count;
               state_in  = (req_cmd == CMD_POP) ? ST_POP_READ : ST_CALC;
            end
         end

         ST_CALC: begin
            weight_in = calc_sum;
            if (count_ff == CNT_W'(QUEUE_DEPTH)) begin
               // Full: reject without using up an id.
               rsp_valid_in  = 1'b1;
               rsp_status_in = STATUS_FULL;
               rsp_id_in     = '0;
               rsp_weight_in = calc_sum;
               rsp_occ_in    = OCC_W'(count_ff);
               state_in      = ST_IDLE;
            end else begin
               last_id_in = next_id;
               id_in      = next_id;
               slot_in    = IDX_W'(count_ff);
               if (count_ff == '0) begin
                  state_in = ST_PLACE;
               end else begin
                  rd_idx   = IDX_W'(count_ff - 1'b1);
                  state_in = ST_WALK;
               end
            end
         end

         ST_WALK: begin
            // rd_data holds the entry just below slot_ff.
            store_ctl.wr_en = 1'b1;
            if (rd_data.weight >= weight_ff) begin
               // Move the heavier entry up one slot and keep walking down.
               wr_data = rd_data;
               slot_in = slot_ff - 1'b1;
               rd_idx  = slot_ff - 1'b1 - 1'b1;
               if (slot_ff == IDX_W'(1)) begin
                  state_in = ST_PLACE;
               end
            end else begin
               count_in      = count_ff + 1'b1;
               rsp_valid_in  = 1'b1;
               rsp_status_in = STATUS_OK;
               rsp_id_in     = id_ff;
               rsp_weight_in = weight_ff;
               rsp_occ_in    = OCC_W'(count_ff + 1'b1);
               state_in      = ST_IDLE;
            end
         end

         ST_PLACE: begin
            store_ctl.wr_en = 1'b1;
            count_in        = count_ff + 1'b1;
            rsp_valid_in    = 1'b1;
            rsp_status_in   = STATUS_OK;
            rsp_id_in       = id_ff;
            rsp_weight_in   = weight_ff;
            rsp_occ_in      = OCC_W'(count_ff + 1'b1);
            state_in        = ST_IDLE;
         end

         ST_POP_READ: begin
            if (count_ff == '0) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = STATUS_EMPTY;
               rsp_id_in     = '0;
               rsp_weight_in = '0;
               rsp_occ_in    = '0;
               state_in      = ST_IDLE;
            end else begin
               rd_idx   = '0;
               state_in = ST_POP_DONE;
            end
         end

         ST_POP_DONE: begin
            store_ctl.advance = 1'b1;
            count_in          = count_ff - 1'b1;
            rsp_valid_in      = 1'b1;
            rsp_status_in     = STATUS_OK;
            rsp_id_in         = rd_data.id;
            rsp_weight_in     = rd_data.weight;
            rsp_occ_in        = OCC_W'(count_ff - 1'b1);
            state_in          = ST_IDLE;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         last_id_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         last_id_ff   <= last_id_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      labels_ff     <= labels_in;
      funcs_ff      <= funcs_in;
      instrs_ff     <= instrs_in;
      weight_ff     <= weight_in;
      id_ff         <= id_in;
      slot_ff       <= slot_in;
      rsp_status_ff <= rsp_status_in;
      rsp_id_ff     <= rsp_id_in;
      rsp_weight_ff <= rsp_weight_in;
      rsp_occ_ff    <= rsp_occ_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_job_id     = rsp_id_ff;
   assign rsp_job_weight = rsp_weight_ff;
   assign rsp_occupancy  = rsp_occ_ff;

endmodule

### hdl/sjnq_checker.sv
// Port-level checker for the shortest-job-next queue, bound to the top level.
`timescale 1ns / 1ps
`include "shortest_job_next_queue_unit_defines.svh"

module sjnq_port_checker
   import sjnq_pkg::*;
(
   input logic                clock,
   input logic                reset,
   input logic                start,
   input logic                busy,
   input logic                rsp_valid,
   input logic [STATUS_W-1:0] rsp_status,
   input logic [ID_W-1:0]     rsp_job_id,
   input logic [WEIGHT_W-1:0] rsp_job_weight,
   input logic [OCC_W-1:0]    rsp_occupancy
);

   `SJNQ_ASSERT_NOW(a_rsp_when_free, clock, reset, rsp_valid, !busy,
      "response while busy")
   `SJNQ_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy,
      "request not taken")
   `SJNQ_ASSERT_NOW(a_empty_zero, clock, reset,
      rsp_valid && (rsp_status == STATUS_EMPTY),
      (rsp_job_id == '0) && (rsp_job_weight == '0) && (rsp_occupancy == '0),
      "empty pop not zero")
   `SJNQ_ASSERT_NOW(a_full_no_id, clock, reset,
      rsp_valid && (rsp_status == STATUS_FULL), rsp_job_id == '0,
      "rejected insert got an id")

endmodule

bind shortest_job_next_queue_unit sjnq_port_checker u_sjnq_checker (
   .clock          (clock),
   .reset          (reset),
   .start          (start),
   .busy           (busy),
   .rsp_valid      (rsp_valid),
   .rsp_status     (rsp_status),
   .rsp_job_id     (rsp_job_id),
   .rsp_job_weight (rsp_job_weight),
   .rsp_occupancy  (rsp_occupancy)
);

### sim/sjnq_checker.sv
// Checker for the shortest-job-next queue: tracks the queue contents and compares responses.
`timescale 1ns / 1ps

module sjnq_checker
   import sjnq_pkg::*;
#(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic                busy,
   input  logic                req_cmd,
   input  logic [FIELD_W-1:0]  req_label_count,
   input  logic [FIELD_W-1:0]  req_function_count,
   input  logic [FIELD_W-1:0]  req_instruction_count,
   input  logic                rsp_valid,
   input  logic [STATUS_W-1:0] rsp_status,
   input  logic [ID_W-1:0]     rsp_job_id,
   input  logic [WEIGHT_W-1:0] rsp_job_weight,
   input  logic [OCC_W-1:0]    rsp_occupancy,
   output int                  mismatch_total,
   output int                  pending_reports
);

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [ID_W-1:0]     job_id;
      logic [WEIGHT_W-1:0] job_weight;
      logic [OCC_W-1:0]    occupancy;
   } job_report_type;

   job_report_type      awaited_reports[$];
   logic [ID_W-1:0]     slot_ids[QUEUE_DEPTH];
   logic [WEIGHT_W-1:0] slot_weights[QUEUE_DEPTH];
   int                  jobs_queued;
   logic [ID_W-1:0]     id_counter;
   int                  mismatches;

   function automatic logic [WEIGHT_W-1:0] job_weight_of(
      input logic [FIELD_W-1:0] labels,
      input logic [FIELD_W-1:0] funcs,
      input logic [FIELD_W-1:0] instrs
   );
      return WEIGHT_W'(5 * int'(labels) + 3 * int'(funcs) + int'(instrs));
   endfunction

   // Apply one request to the tracked queue and record the response it owes.
   task automatic admit_or_pop(input logic cmd, input logic [FIELD_W-1:0] labels,
                               input logic [FIELD_W-1:0] funcs,
                               input logic [FIELD_W-1:0] instrs);
      job_report_type report;
      int pos;
      report = '0;
      if (cmd == CMD_INSERT) begin
         report.job_weight = job_weight_of(labels, funcs, instrs);
         if (jobs_queued >= QUEUE_DEPTH) begin
            report.status = STATUS_FULL;
         end else begin
            id_counter = id_counter + 1'b1;
            report.job_id = id_counter;
            pos = 0;
            while (pos < jobs_queued && slot_weights[pos] < report.job_weight)
               pos++;
            for (int k = jobs_queued; k > pos; k--) begin
               slot_ids[k]     = slot_ids[k-1];
               slot_weights[k] = slot_weights[k-1];
            end
            slot_ids[pos]     = id_counter;
            slot_weights[pos] = report.job_weight;
            jobs_queued++;
            report.status = STATUS_OK;
         end
      end else if (jobs_queued == 0) begin
         report.status = STATUS_EMPTY;
      end else begin
         report.status     = STATUS_OK;
         report.job_id     = slot_ids[0];
         report.job_weight = slot_weights[0];
         for (int k = 1; k < jobs_queued; k++) begin
            slot_ids[k-1]     = slot_ids[k];
            slot_weights[k-1] = slot_weights[k];
         end
         jobs_queued--;
      end
      report.occupancy = OCC_W'(jobs_queued);
      awaited_reports.push_back(report);
   endtask

   task automatic compare_field(input string name, input int unsigned wanted,
                                input int unsigned seen);
      if (wanted != seen) begin
         $error("%s: expected %0d, actual %0d", name, wanted, seen);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      job_report_type wanted;
      if (reset) begin
         jobs_queued = 0;
         id_counter  = '0;
         awaited_reports.delete();
      end else begin
         // Retire the response first: a request taken at this edge answers later.
         if (rsp_valid) begin
            if (awaited_reports.size() == 0) begin
               $error("response: expected none, actual status %0d id %0d",
                      rsp_status, rsp_job_id);
               mismatches++;
            end else begin
               wanted = awaited_reports.pop_front();
               compare_field("status", wanted.status, rsp_status);
               compare_field("job_id", wanted.job_id, rsp_job_id);
               compare_field("job_weight", wanted.job_weight, rsp_job_weight);
               compare_field("occupancy", wanted.occupancy, rsp_occupancy);
            end
         end
         if (start && !busy)
            admit_or_pop(req_cmd, req_label_count, req_function_count,
                         req_instruction_count);
      end
      mismatch_total  <= mismatches;
      pending_reports <= awaited_reports.size();
   end

endmodule

### sim/tb_shortest_job_next_queue_unit.sv
// Testbench top for the shortest-job-next queue: clock, reset, request stimulus and verdict.
`timescale 1ns / 1ps

module tb_shortest_job_next_queue_unit;
   import sjnq_pkg::*;

   localparam int QUEUE_DEPTH = 16;
   localparam int STALL_LIMIT = 2000;
   localparam int MAX_GAP     = 20;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                start = 1'b0;
   logic                busy;
   logic                req_cmd = CMD_INSERT;
   logic [FIELD_W-1:0]  req_label_count = '0;
   logic [FIELD_W-1:0]  req_function_count = '0;
   logic [FIELD_W-1:0]  req_instruction_count = '0;
   logic                rsp_valid;
   logic [STATUS_W-1:0] rsp_status;
   logic [ID_W-1:0]     rsp_job_id;
   logic [WEIGHT_W-1:0] rsp_job_weight;
   logic [OCC_W-1:0]    rsp_occupancy;

   int mismatch_total;
   int pending_reports;
   int idle_pct = 0;
   int quiet_cycles = 0;

   shortest_job_next_queue_unit #(.QUEUE_DEPTH(QUEUE_DEPTH)) dut (.*);

   sjnq_checker #(.QUEUE_DEPTH(QUEUE_DEPTH)) queue_checker (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // End the run if neither a request nor a response moves for too long.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles + 1 >= STALL_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
         end
      end
   end

   // Hold the request until taken, then idle a random number of cycles.
   task automatic issue_request(input logic cmd, input logic [FIELD_W-1:0] labels,
                                input logic [FIELD_W-1:0] funcs,
                                input logic [FIELD_W-1:0] instrs);
      int gap;
      start                 <= 1'b1;
      req_cmd               <= cmd;
      req_label_count       <= labels;
      req_function_count    <= funcs;
      req_instruction_count <= instrs;
      @(posedge clock);
      while (busy) @(posedge clock);
      gap = 0;
      while (gap < MAX_GAP && $urandom_range(0, 99) < idle_pct)
         gap++;
      if (gap > 0) begin
         start                 <= 1'b0;
         req_cmd               <= 1'($urandom);
         req_label_count       <= FIELD_W'($urandom);
         req_function_count    <= FIELD_W'($urandom);
         req_instruction_count <= FIELD_W'($urandom);
         repeat (gap) @(posedge clock);
      end
   endtask

   // Favor extremes and tiny values so that equal weights show up often.
   function automatic logic [FIELD_W-1:0] pick_count();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return '1;
         2, 3:    return FIELD_W'($urandom_range(0, 3));
         default: return FIELD_W'($urandom);
      endcase
   endfunction

   task automatic run_random(input int items, input int pct);
      int insert_pct;
      idle_pct   = pct;
      insert_pct = 50;
      for (int i = 0; i < items; i++) begin
         // Swing between filling and draining so both full and empty get hit.
         if (i % 40 == 0) begin
            case ($urandom_range(0, 2))
               0:       insert_pct = 25;
               1:       insert_pct = 50;
               default: insert_pct = 80;
            endcase
         end
         issue_request(($urandom_range(0, 99) < insert_pct) ? CMD_INSERT : CMD_POP,
                       pick_count(), pick_count(), pick_count());
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed requests.
      idle_pct = 0;
      issue_request(CMD_POP, '0, '0, '0);
      issue_request(CMD_INSERT, '0, '0, '0);
      issue_request(CMD_INSERT, '1, '1, '1);
      issue_request(CMD_INSERT, 16'd1, 16'd0, 16'd0);
      issue_request(CMD_INSERT, 16'd0, 16'd1, 16'd2);
      issue_request(CMD_INSERT, 16'd0, 16'd0, 16'd5);
      issue_request(CMD_INSERT, 16'd0, 16'd0, 16'd4);
      // Descending weights force the longest walks.
      for (int k = 0; k < 10; k++)
         issue_request(CMD_INSERT, '0, '0, FIELD_W'(900 - 80 * k));
      issue_request(CMD_INSERT, '1, '1, '1);
      issue_request(CMD_INSERT, '0, '0, '0);
      issue_request(CMD_POP, '1, 16'hA5A5, 16'h5A5A);
      issue_request(CMD_INSERT, 16'h8000, 16'h0001, 16'h7FFF);

      // Drain the queue.
      repeat (QUEUE_DEPTH) issue_request(CMD_POP, '0, '0, '0);

      run_random(480, 18);
      run_random(480, 74);
      run_random(490, 0);

      start <= 1'b0;
      while (pending_reports != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (mismatch_total == 0 && pending_reports == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
